// ===== rtl/glsu_pkg.sv =====
// Shared types and constants for the grid Laplacian stencil unit.
// No dependencies; glsu_addr_gen, glsu_datapath and the top level import it.
package glsu_pkg;

    // Fixed field widths of the ports
    localparam int ROW_W      = 6;
    localparam int SAMPLE_IN_W = 16;
    localparam int LAP_W      = 16;
    localparam int SIZE_W     = 7;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Smallest grid side that the stencil supports
    localparam int MIN_SIZE = 3;

    // Operation codes
    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SCALE = 2'd2;

    // Boundary modes
    localparam logic BND_PERIODIC = 1'b0;
    localparam logic BND_MIRROR   = 1'b1;

    // Stencil taps, in read order
    localparam logic [2:0] NB_CENTER = 3'd0;
    localparam logic [2:0] NB_NORTH  = 3'd1;
    localparam logic [2:0] NB_SOUTH  = 3'd2;
    localparam logic [2:0] NB_EAST   = 3'd3;
    localparam logic [2:0] NB_WEST   = 3'd4;

    // Control from the sequencer to the datapath
    typedef struct packed {
        logic acc_en;     // add the tap that the memory returns
        logic acc_center; // tap is the center: restart the sum with -4 * C
        logic mul_en;     // scale the finished sum
        logic out_en;     // shift, clip and load the result registers
        logic err;        // result is an index error
    } dp_ctl_t;

endpackage

// ===== rtl/glsu_grid_mem.sv =====
// Grid sample store: one write port, one read port with registered data.
// Depends on nothing; contents are undefined until written.
module glsu_grid_mem #(
    parameter int AW = 12,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1 << AW)-1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/glsu_addr_gen.sv =====
// Neighbor address generator: moves one coordinate by two cells with
// periodic wrap or mirror at the edges. Depends on glsu_pkg.
module glsu_addr_gen #(
    parameter int GRID_MAX = 64
) (
    input  logic [((GRID_MAX > 1) ? $clog2(GRID_MAX) : 1)-1:0]        row_i,
    input  logic [((GRID_MAX > 1) ? $clog2(GRID_MAX) : 1)-1:0]        col_i,
    input  logic [(($clog2(GRID_MAX+1) > 7) ? $clog2(GRID_MAX+1) : 7)-1:0] size,
    input  logic                                                       mode,
    input  logic [2:0]                                                 sel,
    output logic [((GRID_MAX > 1) ? $clog2(GRID_MAX) : 1)-1:0]        row_o,
    output logic [((GRID_MAX > 1) ? $clog2(GRID_MAX) : 1)-1:0]        col_o
);
    import glsu_pkg::*;

    localparam int IDX_W = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int SZ_W  = $clog2(GRID_MAX + 1);
    localparam int N_W   = (SZ_W > 7) ? SZ_W : 7;
    localparam int CW    = N_W + 1;

    logic          use_row;
    logic [CW-1:0] coord;
    logic [CW-1:0] n_ext;
    logic [CW-1:0] up;
    logic [CW-1:0] fwd;
    logic [CW-1:0] back;
    logic [CW-1:0] moved;

    assign use_row = (sel == NB_NORTH) || (sel == NB_SOUTH);
    assign coord   = use_row ? CW'(row_i) : CW'(col_i);
    assign n_ext   = CW'(size);
    assign up      = coord + CW'(2);

    // Forward step: past the last cell wrap around or fold back
    always_comb
    begin
        if (up < n_ext)
        begin
            fwd = up;
        end
        else if (mode == BND_MIRROR)
        begin
            fwd = (n_ext << 1) - CW'(4) - coord;
        end
        else
        begin
            fwd = up - n_ext;
        end
    end

    // Backward step: before the first cell wrap around or fold back
    always_comb
    begin
        if (coord >= CW'(2))
        begin
            back = coord - CW'(2);
        end
        else if (mode == BND_MIRROR)
        begin
            back = CW'(2) - coord;
        end
        else
        begin
            back = coord + n_ext - CW'(2);
        end
    end

    always_comb
    begin
        case (sel)
            NB_NORTH, NB_WEST: moved = back;
            NB_SOUTH, NB_EAST: moved = fwd;
            default:           moved = coord;
        endcase
    end

    always_comb
    begin
        row_o = row_i;
        col_o = col_i;
        if (sel != NB_CENTER)
        begin
            if (use_row)
            begin
                row_o = moved[IDX_W-1:0];
            end
            else
            begin
                col_o = moved[IDX_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/glsu_datapath.sv =====
// Shared accumulator, scale multiplier and output clip for the stencil.
// Depends on glsu_pkg for the control struct and field widths.
module glsu_datapath #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 clk,
    input  glsu_pkg::dp_ctl_t                    ctl,
    input  logic signed [SAMPLE_WIDTH-1:0]       tap,
    input  logic [glsu_pkg::SCALE_W-1:0]         scale,
    output logic signed [glsu_pkg::LAP_W-1:0]    laplacian,
    output logic                                 saturated,
    output logic                                 index_error
);
    import glsu_pkg::*;

    localparam int ACC_W  = SAMPLE_WIDTH + 4;
    localparam int PROD_W = ACC_W + SCALE_W + 1;
    localparam int Q_W    = PROD_W - 8;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (LAP_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  term;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [Q_W-1:0]    q;
    logic signed [LAP_W-1:0]  lap_reg;
    logic                     sat_reg;
    logic                     err_reg;

    // Center tap opens the sum with -4 * C; the others add in
    always_comb
    begin
        if (ctl.acc_center)
        begin
            term     = -(ACC_W'(tap) <<< 2);
            acc_next = term;
        end
        else
        begin
            term     = ACC_W'(tap);
            acc_next = acc_reg + term;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= PROD_W'(acc_reg) * PROD_W'($signed({1'b0, scale}));
        end
    end

    // Arithmetic shift floors toward minus infinity
    assign q = Q_W'(prod_reg >>> 8);

    always_ff @(posedge clk)
    begin
        if (ctl.out_en)
        begin
            err_reg <= ctl.err;
            if (ctl.err)
            begin
                lap_reg <= '0;
                sat_reg <= 1'b0;
            end
            else if (q > Q_MAX)
            begin
                lap_reg <= LAP_W'(Q_MAX);
                sat_reg <= 1'b1;
            end
            else if (q < Q_MIN)
            begin
                lap_reg <= LAP_W'(Q_MIN);
                sat_reg <= 1'b1;
            end
            else
            begin
                lap_reg <= LAP_W'(q);
                sat_reg <= 1'b0;
            end
        end
    end

    assign laplacian   = lap_reg;
    assign saturated   = sat_reg;
    assign index_error = err_reg;

endmodule

// ===== rtl/grid_laplacian_stencil_unit.sv =====
// Top level of the grid Laplacian stencil unit: configuration registers,
// sequencer and grid store. Depends on glsu_pkg, glsu_grid_mem,
// glsu_addr_gen and glsu_datapath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  command   | start / busy         | operation, row, col, sample
//  result    | done (1-cycle pulse) | laplacian, saturated, index_error
//  config    | cfg_write            | cfg_index, cfg_data
//
// A command transfers on a rising edge with start high and busy low.
// A write command stores its cell at that edge and leaves busy low, so a
// new command can follow in the next cycle.
// A compute command holds busy high: five reads of the single grid
// memory port, one per cycle, feed one shared accumulator, then a drain
// state takes the last read, a multiply state scales the sum and a clip
// state loads the result. done pulses in the cycle after the clip, with busy
// already low. An out-of-range compute skips the reads and goes to the clip.
// rst_n clears the sequencer and configuration at once; the grid store is
// not cleared and a cell must be written before it is read.
// The receiver cannot stall: each result is valid for the done cycle only.
module grid_laplacian_stencil_unit #(
    parameter int GRID_MAX     = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  operation,
    input  logic [glsu_pkg::ROW_W-1:0]            row,
    input  logic [glsu_pkg::ROW_W-1:0]            col,
    input  logic signed [glsu_pkg::SAMPLE_IN_W-1:0] sample,
    output logic                                  done,
    output logic signed [glsu_pkg::LAP_W-1:0]     laplacian,
    output logic                                  saturated,
    output logic                                  index_error,
    input  logic                                  cfg_write,
    input  logic [glsu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [glsu_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import glsu_pkg::*;

    localparam int IDX_W = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int SZ_W  = $clog2(GRID_MAX + 1);
    localparam int N_W   = (SZ_W > 7) ? SZ_W : 7;
    localparam int AW    = 2 * IDX_W;
    localparam int EXT_W = ((SAMPLE_WIDTH > SAMPLE_IN_W) ? SAMPLE_WIDTH : SAMPLE_IN_W) + 1;
    localparam logic signed [EXT_W-1:0] SMP_HI =
        EXT_W'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [EXT_W-1:0] SMP_LO = -SMP_HI - EXT_W'(1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    // Configuration registers
    logic [SIZE_W-1:0]  grid_size_reg;
    logic               boundary_mode_reg;
    logic [SCALE_W-1:0] inv_scale_reg;

    // Sequencer
    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [2:0]       step_reg;
    logic [2:0]       step_next;
    logic             rd_valid_reg;
    logic [2:0]       rd_sel_reg;
    logic             err_reg;
    logic             err_next;
    logic             done_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;

    logic             accept;
    logic [N_W-1:0]   size_ext;
    logic [N_W-1:0]   size_use;
    logic [N_W-1:0]   row_ext;
    logic [N_W-1:0]   col_ext;
    logic             bad_index;

    logic signed [EXT_W-1:0]        sample_ext;
    logic signed [SAMPLE_WIDTH-1:0] sample_fit;
    logic                           mem_we;
    logic [IDX_W-1:0]               rd_row;
    logic [IDX_W-1:0]               rd_col;
    logic [SAMPLE_WIDTH-1:0]        rdata;
    dp_ctl_t                        ctl;

    assign accept = start && !busy;

    // Clamp the grid size in use to the range the stencil supports
    assign size_ext = N_W'(grid_size_reg);
    always_comb
    begin
        if (size_ext < N_W'(MIN_SIZE))
        begin
            size_use = N_W'(MIN_SIZE);
        end
        else if (size_ext > N_W'(GRID_MAX))
        begin
            size_use = N_W'(GRID_MAX);
        end
        else
        begin
            size_use = size_ext;
        end
    end

    assign row_ext   = N_W'(row);
    assign col_ext   = N_W'(col);
    assign bad_index = (row_ext >= size_use) || (col_ext >= size_use);

    // Clip the incoming sample to the width of the store
    assign sample_ext = EXT_W'(sample);
    always_comb
    begin
        if (sample_ext > SMP_HI)
        begin
            sample_fit = SAMPLE_WIDTH'(SMP_HI);
        end
        else if (sample_ext < SMP_LO)
        begin
            sample_fit = SAMPLE_WIDTH'(SMP_LO);
        end
        else
        begin
            sample_fit = SAMPLE_WIDTH'(sample_ext);
        end
    end

    // Write commands go straight into the store; out-of-range ones drop
    assign mem_we = accept && (operation == OP_WRITE) && !bad_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg     <= SIZE_W'(64);
            boundary_mode_reg <= BND_PERIODIC;
            inv_scale_reg     <= SCALE_W'(256);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_SIZE: grid_size_reg     <= cfg_data[SIZE_W-1:0];
                REG_BOUNDARY:  boundary_mode_reg <= cfg_data[0];
                REG_INV_SCALE: inv_scale_reg     <= cfg_data[SCALE_W-1:0];
                default:       grid_size_reg     <= grid_size_reg;
            endcase
        end
    end

    // Sequencer: five tap reads, drain, multiply, clip; a bad index goes to clip
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        err_next   = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_COMPUTE))
                begin
                    step_next = NB_CENTER;
                    err_next  = bad_index;
                    state_next = bad_index ? ST_SAT : ST_READ;
                end
            end
            ST_READ:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == NB_WEST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_MUL;
            ST_MUL:   state_next = ST_SAT;
            ST_SAT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= NB_CENTER;
            rd_valid_reg <= 1'b0;
            rd_sel_reg   <= NB_CENTER;
            err_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            rd_valid_reg <= (state_reg == ST_READ);
            rd_sel_reg   <= step_reg;
            err_reg      <= err_next;
            done_reg     <= (state_reg == ST_SAT);
        end
    end

    // Hold the cell position for the whole compute
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= row_ext[IDX_W-1:0];
            col_reg <= col_ext[IDX_W-1:0];
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    assign ctl.acc_en     = rd_valid_reg;
    assign ctl.acc_center = (rd_sel_reg == NB_CENTER);
    assign ctl.mul_en     = (state_reg == ST_MUL);
    assign ctl.out_en     = (state_reg == ST_SAT);
    assign ctl.err        = err_reg;

    glsu_addr_gen #(
        .GRID_MAX (GRID_MAX)
    ) u_addr_gen (
        .row_i (row_reg),
        .col_i (col_reg),
        .size  (size_use),
        .mode  (boundary_mode_reg),
        .sel   (step_reg),
        .row_o (rd_row),
        .col_o (rd_col)
    );

    glsu_grid_mem #(
        .AW (AW),
        .DW (SAMPLE_WIDTH)
    ) u_grid_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr ({row_ext[IDX_W-1:0], col_ext[IDX_W-1:0]}),
        .wdata (sample_fit),
        .raddr ({rd_row, rd_col}),
        .rdata (rdata)
    );

    glsu_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .ctl         (ctl),
        .tap         ($signed(rdata)),
        .scale       (inv_scale_reg),
        .laplacian   (laplacian),
        .saturated   (saturated),
        .index_error (index_error)
    );

    // A result pulse comes only once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // A compute transfer must take the block busy
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_COMPUTE)) |=> busy)
        else $error("compute transfer left block idle");

    // An index error result carries zero and no clip flag
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && index_error) |-> ((laplacian == '0) && !saturated))
        else $error("index error result not zero");

    // The read step never runs past the last tap
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (step_reg <= NB_WEST))
        else $error("read step out of range");

    // A write transfer never produces a result pulse next cycle
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_WRITE)) |=> !done)
        else $error("write produced a result");

endmodule
